/* rtl/sat_pkg.sv */
`timescale 1ns / 1ps

package sat_pkg;

  localparam int NUM_SLOTS = 192;
  localparam int IDX_W     = $clog2(NUM_SLOTS);

  localparam int MODE_W = 3;
  localparam int ID_W   = 8;
  localparam int CNT_W  = 32;
  localparam int STAT_W = 3;

  localparam int IN_USED  = MODE_W + ID_W + 1 + 3 * CNT_W;
  localparam int IN_W     = ((IN_USED + 7) / 8) * 8;
  localparam int OUT_USED = STAT_W + ID_W + CNT_W + 1;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  localparam int GRP     = 16;
  localparam int GRP_W   = $clog2(GRP);
  localparam int NUM_GRP = (NUM_SLOTS + GRP - 1) / GRP;
  localparam int PAD_W   = NUM_GRP * GRP;

  localparam int RSV_ID_A = 26;
  localparam int RSV_ID_B = 27;

  typedef enum logic [MODE_W-1:0] {
    OP_RESERVE  = 3'd0,
    OP_ALLOC    = 3'd1,
    OP_QUERY    = 3'd2,
    OP_EXPIRE   = 3'd3,
    OP_ADD_MAX  = 3'd4,
    OP_READ_MIN = 3'd5,
    OP_LOAD_MIN = 3'd6,
    OP_FENCE    = 3'd7
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_BUSY       = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_UNRESERVED = 3'd3,
    STAT_RANGE      = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* rtl/sat_ctrl.sv */
`timescale 1ns / 1ps

module sat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sat_pkg::sts_t sts_i,
  output sat_pkg::cmd_t cmd_o
);
  import sat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/sat_dpath.sv */
`timescale 1ns / 1ps

module sat_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sat_pkg::cmd_t                cmd_i,
  output sat_pkg::sts_t                sts_o,
  input  logic [sat_pkg::MODE_W-1:0]   mode_i,
  input  logic [sat_pkg::ID_W-1:0]     slot_id_i,
  input  logic                         client_managed_i,
  input  logic [sat_pkg::CNT_W-1:0]    threshold_i,
  input  logic [sat_pkg::CNT_W-1:0]    amount_i,
  input  logic [sat_pkg::CNT_W-1:0]    hw_counter_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [sat_pkg::STAT_W-1:0]   status_o,
  output logic [sat_pkg::ID_W-1:0]     result_id_o,
  output logic [sat_pkg::CNT_W-1:0]    result_value_o,
  output logic                         result_flag_o
);
  import sat_pkg::*;

  localparam logic [NUM_SLOTS-1:0] ONE_HOT0 = NUM_SLOTS'(1);
  localparam logic [NUM_SLOTS-1:0] RSV_INIT = (ONE_HOT0 << RSV_ID_A) | (ONE_HOT0 << RSV_ID_B);

  logic [NUM_SLOTS-1:0] rsv_q, cli_q, cnt_vld_q;
  logic [CNT_W-1:0]     min_mem [NUM_SLOTS];
  logic [CNT_W-1:0]     max_mem [NUM_SLOTS];

  op_e              mode_q;
  logic [IDX_W-1:0] idx_q;
  logic [ID_W-1:0]  id_q;
  logic             cm_q, in_range_q, slot_rsv_q, slot_cli_q, cnt_v_q;
  logic [CNT_W-1:0] thr_q, amt_q, hw_q, min_rd_q, max_rd_q;

  logic [NUM_GRP-1:0] grp_any_q, grp_any_d;
  logic [GRP_W-1:0]   grp_idx_q [NUM_GRP];
  logic [GRP_W-1:0]   grp_idx_d [NUM_GRP];

  logic                out_valid_q;
  logic [STAT_W-1:0]   status_q;
  logic [ID_W-1:0]     result_id_q;
  logic [CNT_W-1:0]    result_value_q;
  logic                result_flag_q;

  logic             in_range;
  logic [IDX_W-1:0] rd_idx;
  logic [PAD_W-1:0] free_vec;

  logic             found_any;
  logic [IDX_W-1:0] found_id;

  logic [CNT_W-1:0] min_val, max_val, max_sum, dmin, dmax;
  status_e          res_status;
  logic [ID_W-1:0]  res_id;
  logic [CNT_W-1:0] res_val;
  logic             res_flag, set_en, min_we, max_we;
  logic [IDX_W-1:0] set_idx;

  assign in_range = {1'b0, slot_id_i} < (ID_W + 1)'(NUM_SLOTS);
  assign rd_idx   = slot_id_i[IDX_W-1:0];
  assign free_vec = PAD_W'(~rsv_q) & ~PAD_W'(1);

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (free_vec[g * GRP + b]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = GRP_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q     <= op_e'(mode_i);
      idx_q      <= rd_idx;
      id_q       <= slot_id_i;
      cm_q       <= client_managed_i;
      thr_q      <= threshold_i;
      amt_q      <= amount_i;
      hw_q       <= hw_counter_i;
      in_range_q <= in_range;
      slot_rsv_q <= in_range & rsv_q[rd_idx];
      slot_cli_q <= in_range & cli_q[rd_idx];
      cnt_v_q    <= in_range & cnt_vld_q[rd_idx];
      min_rd_q   <= min_mem[rd_idx];
      max_rd_q   <= max_mem[rd_idx];
      grp_any_q  <= grp_any_d;
      grp_idx_q  <= grp_idx_d;
    end
  end

  always_comb begin
    found_any = 1'b0;
    found_id  = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_any = 1'b1;
        found_id  = IDX_W'(g * GRP) + IDX_W'(grp_idx_q[g]);
      end
    end
  end

  assign min_val = cnt_v_q ? min_rd_q : '0;
  assign max_val = cnt_v_q ? max_rd_q : '0;
  assign max_sum = max_val + amt_q;
  assign dmin    = min_val - thr_q;
  assign dmax    = max_val - thr_q;

  always_comb begin
    res_status = STAT_OK;
    res_id     = '0;
    res_val    = '0;
    res_flag   = 1'b0;
    set_en     = 1'b0;
    set_idx    = idx_q;
    min_we     = 1'b0;
    max_we     = 1'b0;
    if (mode_q == OP_ALLOC) begin
      if (found_any) begin
        set_en  = 1'b1;
        set_idx = found_id;
        res_id  = ID_W'(found_id);
      end else begin
        res_status = STAT_FULL;
      end
    end else if (!in_range_q) begin
      res_status = STAT_RANGE;
    end else if (mode_q == OP_RESERVE) begin
      if (slot_rsv_q) begin
        res_status = STAT_BUSY;
      end else begin
        set_en = 1'b1;
        res_id = id_q;
      end
    end else if (mode_q == OP_QUERY) begin
      res_flag = slot_rsv_q;
    end else if (!slot_rsv_q) begin
      res_status = STAT_UNRESERVED;
    end else begin
      case (mode_q)
        OP_EXPIRE: begin
          res_flag = slot_cli_q ? ~dmin[CNT_W-1] : (dmax >= dmin);
        end
        OP_ADD_MAX: begin
          max_we  = 1'b1;
          res_val = max_sum;
        end
        OP_READ_MIN: begin
          res_val = min_val;
        end
        OP_LOAD_MIN: begin
          min_we  = 1'b1;
          res_val = hw_q;
        end
        OP_FENCE: begin
          res_id  = id_q;
          res_val = max_val;
        end
        default: begin
          res_val = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_q       <= RSV_INIT;
      cli_q       <= RSV_INIT;
      cnt_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit && set_en) begin
        rsv_q[set_idx] <= 1'b1;
        cli_q[set_idx] <= cm_q;
      end
      if (cmd_i.commit && (min_we || max_we)) begin
        cnt_vld_q[idx_q] <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (min_we || max_we)) begin
      min_mem[idx_q] <= min_we ? hw_q : min_val;
      max_mem[idx_q] <= max_we ? max_sum : max_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q       <= res_status;
      result_id_q    <= res_id;
      result_value_q <= res_val;
      result_flag_q  <= res_flag;
    end
  end

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_id_o    = result_id_q;
  assign result_value_o = result_value_q;
  assign result_flag_o  = result_flag_q;

endmodule

/* rtl/syncpoint_allocator_table.sv */
// Syncpoint allocator table.
// Slave channel (s_axis_*): one operation item per handshake; tdata carries
// mode, slot_id, client_managed, threshold, amount and hw_counter, lowest bit up.
// Master channel (m_axis_*): exactly one result item per operation; tdata
// carries status, result_id, result_value and result_flag, lowest bit up.
// An item is captured together with a registered read of the counter memories
// and a first-level free-slot search; then the execute state resolves the lowest
// free id above 0 and commits the read-modify-write of one counter entry and the
// reserved/client bits.
// One item is in flight at a time; s_axis_tready is low while it executes.
// Reset: all entries free and counters zero, except ids 26 and 27 reserved as
// client managed; no clearing pass, the block is ready the cycle after reset.
// Stall: a result waits in the output register while m_axis_tready is low; the
// next item is still accepted, and its result holds back until the register
// frees up.
`timescale 1ns / 1ps

module syncpoint_allocator_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // mode[2:0], slot_id[10:3], client_managed[11], threshold[43:12],
  // amount[75:44], hw_counter[107:76], zero pad above
  input  logic [sat_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status[2:0], result_id[10:3], result_value[42:11], result_flag[43],
  // zero pad above
  output logic [sat_pkg::OUT_W-1:0]  m_axis_tdata
);
  import sat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   result_id;
  logic [CNT_W-1:0]  result_value;
  logic              result_flag;

  sat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sat_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (s_axis_tdata[2:0]),
    .slot_id_i        (s_axis_tdata[10:3]),
    .client_managed_i (s_axis_tdata[11]),
    .threshold_i      (s_axis_tdata[43:12]),
    .amount_i         (s_axis_tdata[75:44]),
    .hw_counter_i     (s_axis_tdata[107:76]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .status_o         (status),
    .result_id_o      (result_id),
    .result_value_o   (result_value),
    .result_flag_o    (result_flag)
  );

  assign m_axis_tdata = {{(OUT_W - OUT_USED){1'b0}}, result_flag, result_value, result_id, status};

endmodule

/* rtl/sat_checker.sv */
`timescale 1ns / 1ps

module sat_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [sat_pkg::IN_W-1:0]   s_axis_tdata,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sat_pkg::OUT_W-1:0]  m_axis_tdata
);
  import sat_pkg::*;

  logic [STAT_W-1:0] st;
  logic              in_acc;

  assign st     = m_axis_tdata[2:0];
  assign in_acc = s_axis_tvalid & s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("second item taken while one executes");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st == STAT_OK || st == STAT_BUSY || st == STAT_FULL ||
                       st == STAT_UNRESERVED || st == STAT_RANGE))
    else $error("undefined status code");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st != STAT_OK |-> m_axis_tdata[43:3] == '0)
    else $error("error result carries payload");

  a_result_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("result missing two cycles after accept");

endmodule

bind syncpoint_allocator_table sat_checker u_sat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sat_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_OPS   = 2000;

  typedef struct {
    status_e     status;
    logic [7:0]  id;
    logic [31:0] value;
    logic        flag;
  } reply_t;

  class syncpoint_ledger;
    bit          reserved[NUM_SLOTS];
    bit          client[NUM_SLOTS];
    logic [31:0] min_cnt[NUM_SLOTS];
    logic [31:0] max_cnt[NUM_SLOTS];
    reply_t      pending_replies[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned full_seen;

    function new();
      foreach (reserved[i]) begin
        reserved[i] = 1'b0;
        client[i]   = 1'b0;
        min_cnt[i]  = '0;
        max_cnt[i]  = '0;
      end
      reserved[RSV_ID_A] = 1'b1;
      client[RSV_ID_A]   = 1'b1;
      reserved[RSV_ID_B] = 1'b1;
      client[RSV_ID_B]   = 1'b1;
      errors    = 0;
      checked   = 0;
      full_seen = 0;
    endfunction

    function int lowest_free();
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (!reserved[i]) return i;
      end
      return 0;
    endfunction

    function void note_op(op_e op, logic [7:0] id, logic cm, logic [31:0] thr,
                          logic [31:0] amt, logic [31:0] hw);
      reply_t      r;
      int          slot;
      logic [31:0] dmin;
      r.status = STAT_OK;
      r.id     = '0;
      r.value  = '0;
      r.flag   = 1'b0;
      if (op == OP_ALLOC) begin
        slot = lowest_free();
        if (slot == 0) begin
          r.status = STAT_FULL;
          full_seen++;
        end else begin
          reserved[slot] = 1'b1;
          client[slot]   = cm;
          r.id           = slot[7:0];
        end
      end else if (int'(id) >= NUM_SLOTS) begin
        r.status = STAT_RANGE;
      end else if (op == OP_RESERVE) begin
        if (reserved[id]) begin
          r.status = STAT_BUSY;
        end else begin
          reserved[id] = 1'b1;
          client[id]   = cm;
          r.id         = id;
        end
      end else if (op == OP_QUERY) begin
        r.flag = reserved[id];
      end else if (!reserved[id]) begin
        r.status = STAT_UNRESERVED;
      end else begin
        case (op)
          OP_EXPIRE: begin
            dmin = min_cnt[id] - thr;
            if (client[id]) begin
              r.flag = ~dmin[31];
            end else begin
              r.flag = ((max_cnt[id] - thr) >= dmin);
            end
          end
          OP_ADD_MAX: begin
            max_cnt[id] = max_cnt[id] + amt;
            r.value     = max_cnt[id];
          end
          OP_READ_MIN: begin
            r.value = min_cnt[id];
          end
          OP_LOAD_MIN: begin
            min_cnt[id] = hw;
            r.value     = hw;
          end
          default: begin
            r.id    = id;
            r.value = max_cnt[id];
          end
        endcase
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [OUT_W-1:0] data);
      reply_t exp_r;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result item %h", $time, data);
        errors++;
        return;
      end
      exp_r = pending_replies.pop_front();
      checked++;
      if (data[2:0] !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, data[2:0]);
        errors++;
      end
      if (data[10:3] !== exp_r.id) begin
        $display("%0t: result_id expected %0d actual %0d", $time, exp_r.id, data[10:3]);
        errors++;
      end
      if (data[42:11] !== exp_r.value) begin
        $display("%0t: result_value expected %h actual %h", $time, exp_r.value,
                 data[42:11]);
        errors++;
      end
      if (data[43] !== exp_r.flag) begin
        $display("%0t: result_flag expected %b actual %b", $time, exp_r.flag, data[43]);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  syncpoint_ledger ledger;
  int unsigned     gap_pct    = 9;
  int unsigned     stall_pct  = 52;
  int unsigned     sent       = 0;
  int unsigned     cycle_count = 0;

  syncpoint_allocator_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      ledger.check_reply(m_axis_tdata);
    end
    m_axis_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_op(op_e op, logic [7:0] id, logic cm, logic [31:0] thr,
                         logic [31:0] amt, logic [31:0] hw);
    logic [IN_W-1:0] word;
    word          = '0;
    word[2:0]     = op;
    word[10:3]    = id;
    word[11]      = cm;
    word[43:12]   = thr;
    word[75:44]   = amt;
    word[107:76]  = hw;
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    ledger.note_op(op, id, cm, thr, amt, hw);
    sent++;
  endtask

  function automatic logic [7:0] pick_slot(bit want_reserved);
    int slot;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(NUM_SLOTS, 255));
    slot = $urandom_range(0, NUM_SLOTS - 1);
    if (want_reserved) begin
      for (int t = 0; t < 64 && !ledger.reserved[slot]; t++) begin
        slot = $urandom_range(0, NUM_SLOTS - 1);
      end
      if (!ledger.reserved[slot]) slot = RSV_ID_A;
    end
    return 8'(slot);
  endfunction

  task automatic send_random_op();
    op_e         op;
    logic [7:0]  id;
    logic [31:0] thr;
    logic [31:0] amt;
    logic [31:0] hw;
    logic [31:0] off;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) op = OP_RESERVE;
    else if (r < 12) op = OP_ALLOC;
    else if (r < 20) op = OP_QUERY;
    else op = op_e'($urandom_range(OP_EXPIRE, OP_FENCE));
    id  = pick_slot(op >= OP_EXPIRE && $urandom_range(0, 99) < 85);
    off = 32'($urandom_range(0, 16)) - 32'd8;
    thr = $urandom();
    hw  = $urandom();
    if (int'(id) < NUM_SLOTS) begin
      case ($urandom_range(0, 3))
        1: thr = ledger.min_cnt[id] + off;
        2: thr = ledger.max_cnt[id] + off;
        3: thr = ledger.min_cnt[id] + 32'h8000_0000 + off;
        default: ;
      endcase
      if ($urandom_range(0, 1)) hw = ledger.max_cnt[id] + off;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: amt = 32'($urandom_range(0, 15));
      5: amt = 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      default: amt = $urandom();
    endcase
    send_op(op, id, 1'($urandom_range(0, 1)), thr, amt, hw);
  endtask

  initial begin
    int unsigned directed;
    ledger = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_op(OP_QUERY, RSV_ID_A, 1'b0, '0, '0, '0);
    send_op(OP_QUERY, 8'd0, 1'b0, '0, '0, '0);
    send_op(OP_RESERVE, RSV_ID_B, 1'b0, '0, '0, '0);
    send_op(OP_RESERVE, 8'd0, 1'b0, '0, '0, '0);
    send_op(OP_EXPIRE, 8'd5, 1'b0, '0, '0, '0);
    send_op(OP_READ_MIN, 8'd3, 1'b1, '0, '0, '0);
    send_op(OP_ADD_MAX, 8'd0, 1'b0, '0, 32'hFFFF_FFFF, '0);
    send_op(OP_ADD_MAX, 8'd0, 1'b0, '0, 32'd1, '0);
    send_op(OP_ADD_MAX, 8'd0, 1'b0, '0, 32'd100, '0);
    send_op(OP_LOAD_MIN, 8'd0, 1'b0, '0, '0, 32'd90);
    send_op(OP_READ_MIN, 8'd0, 1'b0, '0, '0, '0);
    send_op(OP_EXPIRE, 8'd0, 1'b0, 32'd95, '0, '0);
    send_op(OP_EXPIRE, 8'd0, 1'b0, 32'd85, '0, '0);
    send_op(OP_EXPIRE, RSV_ID_A, 1'b0, 32'd0, '0, '0);
    send_op(OP_EXPIRE, RSV_ID_A, 1'b0, 32'd1, '0, '0);
    send_op(OP_LOAD_MIN, RSV_ID_A, 1'b0, '0, '0, 32'h8000_0000);
    send_op(OP_EXPIRE, RSV_ID_A, 1'b0, 32'd0, '0, '0);
    send_op(OP_FENCE, RSV_ID_A, 1'b0, '0, '0, '0);
    send_op(OP_ALLOC, 8'd255, 1'b1, '0, '0, '0);
    send_op(OP_ALLOC, 8'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_RESERVE, 8'(NUM_SLOTS - 1), 1'b1, '0, '0, '0);
    send_op(OP_FENCE, 8'(NUM_SLOTS - 1), 1'b0, '0, '0, '0);
    send_op(OP_RESERVE, 8'(NUM_SLOTS), 1'b0, '0, '0, '0);
    send_op(OP_QUERY, 8'd255, 1'b0, '0, '0, '0);
    send_op(OP_READ_MIN, 8'd200, 1'b0, '0, '0, '0);
    directed = sent;

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 3) begin
        gap_pct   = 52;
        stall_pct = 9;
      end else if (i == 2 * RANDOM_OPS / 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      send_random_op();
    end

    // fill the table, then hit the no-free-entry case
    while (ledger.lowest_free() != 0) begin
      send_op(OP_ALLOC, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), '0, '0, '0);
    end
    repeat (3) send_op(OP_ALLOC, 8'($urandom_range(0, 255)), 1'b0, '0, '0, '0);
    repeat (40) send_random_op();

    s_axis_tvalid <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d operation items (%0d directed), checked %0d results.",
             sent, directed, ledger.checked);
    $display("Allocation on a full table was seen %0d times.", ledger.full_seen);
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
